>>> rtl/mols_pkg.sv
// Package for the median-of-loaded-set block: sizes, sequencer states
// and the request/response bundles between the top level and the select unit.
// No dependencies.
`timescale 1ns / 1ps

package mols_pkg;

  // Store depth and sample width
  localparam int CAPACITY     = 256;
  localparam int SAMPLE_WIDTH = 32;

  // Derived widths
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int BIT_W    = $clog2(SAMPLE_WIDTH);
  localparam int RESULT_W = SAMPLE_WIDTH + 1;

  // Sign flip: stored values compare unsigned in signed order
  localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [BIT_W-1:0]        TOP_BIT  = BIT_W'(SAMPLE_WIDTH - 1);

  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_SCAN,
    SEL_DONE
  } sel_state_e;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] count;
  } sel_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [RESULT_W-1:0] median;
    logic [COUNT_W-1:0]  count;
  } sel_rsp_t;

endpackage

>>> rtl/median_of_loaded_set.sv
// Top level of the median-of-loaded-set block: load control, fill count,
// overflow tracking and the output register. Uses mols_store and mols_select.
//
//   channel | signals                                          | dir
//   in      | in_valid_i, in_stall_o, sample_i, last_i         | beat in
//   out     | out_valid_o, out_stall_i, median_doubled_o,      | beat out
//           | sample_count_o, overflow_o                       |
//
// Samples load at one beat per cycle while in_stall_o is low. After the last
// beat of a set the select unit settles one result bit per pass over the n
// kept samples; an even count takes twice as many passes as an odd one.
// in_stall_o stays high from the last beat until the result moves into the
// output register. Reset clears the fill count, overflow flag, sequencer and
// output valid; the store needs no clearing.
`timescale 1ns / 1ps

module median_of_loaded_set (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mols_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mols_pkg::RESULT_W-1:0] median_doubled_o,
  output logic [mols_pkg::COUNT_W-1:0]         sample_count_o,
  output logic                                 overflow_o
);
  import mols_pkg::*;

  logic                    in_acc;
  logic                    room;
  logic [COUNT_W-1:0]      fill_q, fill_d;
  logic                    ovf_q, ovf_d;
  logic [COUNT_W-1:0]      count_new;
  logic                    ovf_new;
  logic                    res_ovf_q;

  sel_req_t                sel_req;
  sel_rsp_t                sel_rsp;
  logic                    sel_ack;

  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [SAMPLE_WIDTH-1:0] rd_data;

  logic                    out_valid_q;
  logic [RESULT_W-1:0]     out_median_q;
  logic [COUNT_W-1:0]      out_count_q;
  logic                    out_ovf_q;

  // Input beat and load bookkeeping
  assign in_stall_o = sel_rsp.busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (fill_q < COUNT_W'(CAPACITY));
  assign count_new  = room ? (fill_q + COUNT_W'(1)) : fill_q;
  assign ovf_new    = ovf_q || !room;

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (in_acc) begin
      if (last_i) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end else begin
        fill_d = count_new;
        ovf_d  = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      res_ovf_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      if (sel_req.start) begin
        res_ovf_q <= ovf_new;
      end
    end
  end

  // Sample store, values kept with the sign bit flipped
  mols_store u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && room),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (sample_i ^ SIGN_BIT),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Selection
  assign sel_req.start = in_acc && last_i;
  assign sel_req.count = count_new;

  mols_select u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sel_req),
    .rsp_o     (sel_rsp),
    .ack_i     (sel_ack),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data)
  );

  // Output register
  assign sel_ack = sel_rsp.done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sel_ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_ack) begin
      out_median_q <= sel_rsp.median;
      out_count_q  <= sel_rsp.count;
      out_ovf_q    <= res_ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = out_median_q;
  assign sample_count_o   = out_count_q;
  assign overflow_o       = out_ovf_q;

endmodule

>>> rtl/mols_store.sv
// Sample store: one write port, one registered read port.
// Depends on mols_pkg.
`timescale 1ns / 1ps

module mols_store (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [mols_pkg::ADDR_W-1:0]      waddr_i,
  input  logic [mols_pkg::SAMPLE_WIDTH-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [mols_pkg::ADDR_W-1:0]      raddr_i,
  output logic [mols_pkg::SAMPLE_WIDTH-1:0] rdata_o
);
  import mols_pkg::*;

  logic [SAMPLE_WIDTH-1:0] mem_q [CAPACITY];
  logic [SAMPLE_WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/mols_select.sv
// Radix select unit: finds the middle order statistics bit by bit, one
// store read and one masked compare per cycle, then forms twice the median.
// Depends on mols_pkg; reads mols_store through its registered port.
`timescale 1ns / 1ps

module mols_select (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mols_pkg::sel_req_t                req_i,
  output mols_pkg::sel_rsp_t                rsp_o,
  input  logic                              ack_i,
  output logic                              rd_en_o,
  output logic [mols_pkg::ADDR_W-1:0]       rd_addr_o,
  input  logic [mols_pkg::SAMPLE_WIDTH-1:0] rd_data_i
);
  import mols_pkg::*;

  sel_state_e              state_q, state_d;
  logic [COUNT_W-1:0]      n_q, n_d;
  logic [ADDR_W-1:0]       k_q, k_d;
  logic                    lo_pass_q, lo_pass_d;
  logic [BIT_W-1:0]        bit_q, bit_d;
  logic [SAMPLE_WIDTH-1:0] prefix_q, prefix_d;
  logic [COUNT_W-1:0]      issue_q, issue_d;
  logic [COUNT_W-1:0]      cnt_q, cnt_d;
  logic                    rd_vld_q;
  logic [SAMPLE_WIDTH-1:0] hi_q, hi_d;
  logic [SAMPLE_WIDTH-1:0] lo_q, lo_d;

  logic                    issue_more;
  logic [SAMPLE_WIDTH-1:0] mask;
  logic                    match;
  logic                    take_one;
  logic [SAMPLE_WIDTH-1:0] sel_val;
  logic [ADDR_W-1:0]       k_next;
  logic [SAMPLE_WIDTH-1:0] hi_u, lo_u;

  // Shared compare: upper bits equal the prefix and the current bit is zero
  assign mask  = {SAMPLE_WIDTH{1'b1}} << bit_q;
  assign match = (((rd_data_i ^ prefix_q) & mask) == '0);

  // Bit decision from the count of values below the candidate
  assign take_one = (COUNT_W'(k_q) >= cnt_q);
  assign sel_val  = take_one ? (prefix_q | (SAMPLE_WIDTH'(1) << bit_q)) : prefix_q;
  assign k_next   = take_one ? ADDR_W'(COUNT_W'(k_q) - cnt_q) : k_q;

  assign issue_more = (issue_q < n_q);
  assign rd_en_o    = (state_q == SEL_SCAN) && issue_more;
  assign rd_addr_o  = issue_q[ADDR_W-1:0];

  // Sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    k_d       = k_q;
    lo_pass_d = lo_pass_q;
    bit_d     = bit_q;
    prefix_d  = prefix_q;
    issue_d   = issue_q;
    cnt_d     = cnt_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    case (state_q)
      SEL_IDLE: begin
        if (req_i.start) begin
          n_d       = req_i.count;
          k_d       = ADDR_W'(req_i.count >> 1);
          lo_pass_d = 1'b0;
          bit_d     = TOP_BIT;
          prefix_d  = '0;
          issue_d   = '0;
          cnt_d     = '0;
          state_d   = SEL_SCAN;
        end
      end
      SEL_SCAN: begin
        if (issue_more) begin
          issue_d = issue_q + COUNT_W'(1);
        end
        if (rd_vld_q && match) begin
          cnt_d = cnt_q + COUNT_W'(1);
        end
        // all beats of this pass counted: settle one bit
        if (!issue_more && !rd_vld_q) begin
          issue_d = '0;
          cnt_d   = '0;
          if (bit_q != '0) begin
            bit_d    = bit_q - BIT_W'(1);
            prefix_d = sel_val;
            k_d      = k_next;
          end else if (!lo_pass_q) begin
            hi_d = sel_val;
            if (n_q[0]) begin
              lo_d    = sel_val;
              state_d = SEL_DONE;
            end else begin
              // even count: also need the order statistic just below
              lo_pass_d = 1'b1;
              k_d       = ADDR_W'((n_q >> 1) - COUNT_W'(1));
              bit_d     = TOP_BIT;
              prefix_d  = '0;
            end
          end else begin
            lo_d    = sel_val;
            state_d = SEL_DONE;
          end
        end
      end
      SEL_DONE: begin
        if (ack_i) begin
          state_d = SEL_IDLE;
        end
      end
      default: begin
        state_d = SEL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEL_IDLE;
      n_q       <= '0;
      k_q       <= '0;
      lo_pass_q <= 1'b0;
      bit_q     <= '0;
      prefix_q  <= '0;
      issue_q   <= '0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      k_q       <= k_d;
      lo_pass_q <= lo_pass_d;
      bit_q     <= bit_d;
      prefix_q  <= prefix_d;
      issue_q   <= issue_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_en_o;
    end
  end

  // Selected values
  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  // Remove the bias and add with sign extension
  assign hi_u = hi_q ^ SIGN_BIT;
  assign lo_u = lo_q ^ SIGN_BIT;

  assign rsp_o.busy   = (state_q != SEL_IDLE);
  assign rsp_o.done   = (state_q == SEL_DONE);
  assign rsp_o.median = {hi_u[SAMPLE_WIDTH-1], hi_u} + {lo_u[SAMPLE_WIDTH-1], lo_u};
  assign rsp_o.count  = n_q;

endmodule
